@@ sv/rtcv_pkg.sv @@
`timescale 1ns / 1ps

package rtcv_pkg;

  localparam logic [10:0] YEAR_BASE    = 11'd1900;
  localparam logic [9:0]  MIN_YEAR_OFF = 10'd70;
  localparam logic [9:0]  MAX_OFFSET   = 10'd169;
  localparam logic [9:0]  CENTURY      = 10'd100;
  localparam logic [11:0] EPOCH_MIN    = 12'd1900;
  localparam logic [11:0] EPOCH_RESET  = 12'd1900;
  localparam logic [7:0]  HOURS_24     = 8'h80;

  typedef struct packed {
    logic       bad;
    logic       leap;
    logic [3:0] mon;
    logic [4:0] date;
    logic [2:0] wday;
    logic [4:0] hrs;
    logic [5:0] min;
    logic [5:0] sec;
    logic [9:0] off;
  } s1_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] mon;
    logic [4:0] date;
    logic [2:0] wday;
    logic [4:0] hrs;
    logic [5:0] min;
    logic [5:0] sec;
    logic [6:0] off;
  } s2_t;

  // Gregorian leap test for 1900 + ysi, with ysi below 1024.
  function automatic logic is_leap(input logic [9:0] ysi);
    logic cent;
    logic quad;
    cent = 1'b0;
    quad = 1'b0;
    for (int k = 0; k <= 10; k++) begin
      if (ysi == 10'(k * 100)) begin
        cent = 1'b1;
        if (((k + 19) % 4) == 0) begin
          quad = 1'b1;
        end
      end
    end
    return (ysi[1:0] == 2'd0) && (!cent || quad);
  endfunction

  // Length of the one-based month; zero for codes that are not months.
  function automatic logic [4:0] month_len(input logic [3:0] mon1, input logic leap);
    logic [4:0] len;
    case (mon1)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      4'd2:                                      len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

@@ sv/rtcv_bcd.sv @@
`timescale 1ns / 1ps

module rtcv_bcd (
  input  logic [6:0] bin,
  output logic [7:0] bcd
);

  logic [14:0] prod;
  logic [3:0]  tens;
  logic [6:0]  ones;

  // Multiplying by 205 and shifting by 11 gives the exact quotient by ten here.
  assign prod = 15'(bin) * 15'd205;
  assign tens = prod[14:11];
  assign ones = bin - 7'(tens) * 7'd10;
  assign bcd  = {tens, ones[3:0]};

endmodule

@@ sv/rtc_time_validate_bcd_encode.sv @@
`timescale 1ns / 1ps

// Validates a broken-down calendar time and encodes it into clock register bytes.
// One beat is accepted per cycle while the output is not stalled; each result passes
// through three register stages (range checks and epoch subtraction, month
// length and century fold, BCD conversion into the output register). Backpressure
// on the output stalls the stages behind it without losing any beat. An invalid time
// gives tuser high and all-zero tdata. Epoch writes below 1900 are ignored.
module rtc_time_validate_bcd_encode (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_data,     // epoch_year
  input  logic        in_tvalid,
  output logic        in_tready,
  // year_since_1900[9:0], month_zero_based[13:10], day_of_month[18:14],
  // weekday[21:19], hours[26:22], minutes[32:27], seconds[38:33], zero[39]
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // seconds_bcd[6:0], minutes_bcd[13:7], hours_reg[21:14], date_bcd[27:22],
  // weekday_reg[30:28], month_bcd[35:31], year_bcd[43:36], zero[47:44]
  output logic [47:0] out_tdata,
  output logic        out_tuser     // status
);

  logic [11:0]        epoch_r;
  logic               v1_r, v2_r, v3_r;
  logic               en1, en2, en3;
  rtcv_pkg::s1_t      s1_r, s1_nxt;
  rtcv_pkg::s2_t      s2_r, s2_nxt;
  logic [47:0]        data_r, data_nxt;
  logic               stat_r, stat_nxt;

  logic [9:0]  ysi;
  logic [3:0]  mon0;
  logic [4:0]  day;
  logic [2:0]  wday;
  logic [4:0]  hrs;
  logic [5:0]  min;
  logic [5:0]  sec;
  logic [11:0] year;
  logic [11:0] diff;

  logic [7:0]  sec_bcd, min_bcd, hrs_bcd, date_bcd, mon_bcd, year_bcd;

  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r <= rtcv_pkg::EPOCH_RESET;
    end else if (cfg_valid && cfg_data >= rtcv_pkg::EPOCH_MIN) begin
      epoch_r <= cfg_data;
    end
  end

  assign en3       = !v3_r || out_tready;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = en1 && rst_n;

  assign ysi  = in_tdata[9:0];
  assign mon0 = in_tdata[13:10];
  assign day  = in_tdata[18:14];
  assign wday = in_tdata[21:19];
  assign hrs  = in_tdata[26:22];
  assign min  = in_tdata[32:27];
  assign sec  = in_tdata[38:33];
  assign year = 12'(ysi) + 12'(rtcv_pkg::YEAR_BASE);
  assign diff = year - epoch_r;

  always_comb begin
    s1_nxt.bad  = (ysi < rtcv_pkg::MIN_YEAR_OFF) || (mon0 > 4'd11) || (day == 5'd0) ||
                  (hrs > 5'd23) || (min > 6'd59) || (sec > 6'd59) || (year < epoch_r);
    s1_nxt.leap = rtcv_pkg::is_leap(ysi);
    s1_nxt.mon  = mon0 + 4'd1;
    s1_nxt.date = day;
    s1_nxt.wday = wday;
    s1_nxt.hrs  = hrs;
    s1_nxt.min  = min;
    s1_nxt.sec  = sec;
    s1_nxt.off  = diff[9:0];
  end

  always_comb begin
    s2_nxt.bad  = s1_r.bad || (s1_r.off > rtcv_pkg::MAX_OFFSET) ||
                  (s1_r.date > rtcv_pkg::month_len(s1_r.mon, s1_r.leap));
    s2_nxt.mon  = s1_r.mon;
    s2_nxt.date = s1_r.date;
    s2_nxt.wday = s1_r.wday;
    s2_nxt.hrs  = s1_r.hrs;
    s2_nxt.min  = s1_r.min;
    s2_nxt.sec  = s1_r.sec;
    if (s1_r.off >= rtcv_pkg::CENTURY) begin
      s2_nxt.off = 7'(s1_r.off - rtcv_pkg::CENTURY);
    end else begin
      s2_nxt.off = s1_r.off[6:0];
    end
  end

  rtcv_bcd u_sec  (.bin({1'b0, s2_r.sec}),    .bcd(sec_bcd));
  rtcv_bcd u_min  (.bin({1'b0, s2_r.min}),    .bcd(min_bcd));
  rtcv_bcd u_hrs  (.bin({2'b00, s2_r.hrs}),   .bcd(hrs_bcd));
  rtcv_bcd u_date (.bin({2'b00, s2_r.date}),  .bcd(date_bcd));
  rtcv_bcd u_mon  (.bin({3'b000, s2_r.mon}),  .bcd(mon_bcd));
  rtcv_bcd u_year (.bin(s2_r.off),            .bcd(year_bcd));

  always_comb begin
    stat_nxt = s2_r.bad;
    if (s2_r.bad) begin
      data_nxt = '0;
    end else begin
      data_nxt = {4'd0, year_bcd, mon_bcd[4:0], s2_r.wday, date_bcd[5:0],
                  hrs_bcd | rtcv_pkg::HOURS_24, min_bcd[6:0], sec_bcd[6:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_tvalid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_r <= s1_nxt;
    end
    if (en2) begin
      s2_r <= s2_nxt;
    end
    if (en3) begin
      data_r <= data_nxt;
      stat_r <= stat_nxt;
    end
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = data_r;
  assign out_tuser  = stat_r;

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("invalid result carries non-zero data");

  a_hours_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> out_tdata[21])
    else $error("valid result lacks the 24-hour bit");

  a_epoch_floor: assert property (@(posedge clk) disable iff (!rst_n)
    epoch_r >= rtcv_pkg::EPOCH_MIN)
    else $error("epoch register below its floor");

  a_bubble_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (!v3_r && v2_r) |=> v3_r)
    else $error("output stage failed to take a waiting beat");

endmodule
